FILE: sv/suffix_array_lcp_builder_macros.svh
// Assertion macros for the suffix array builder checker
`ifndef SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define SALB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock edge outside reset
`define SALB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/salb_pkg.sv
// Shared types and constants of the suffix array and LCP builder
package salb_pkg;

    localparam int MAX_LEN    = 4096;
    localparam int AW         = 13;   // address/rank width, covers 0..MAX_LEN
    localparam int CODE_W     = 7;
    localparam int LCP_W      = 12;
    localparam int ALPHA_KEYS = 128;  // largest code plus one

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] char_code;
        logic              last_char;
        logic [AW-1:0]     index;
    } t_in_item;

    typedef struct packed {
        logic [AW-1:0]    suffix_start;
        logic [LCP_W-1:0] lcp;
        logic [AW-1:0]    rank_of_position;
        logic             out_of_range;
        logic             overflowed;
    } t_out_item;

endpackage

FILE: sv/suffix_array_lcp_builder.sv
// An append is written to the text memory as it is accepted. A read is registered at the memory read
// port, then loaded into the output register, which waits while an earlier result is held by an output stall.
// One append per cycle while idle with no read pending; any new item waits until a pending read is loaded.
// Build after the last character stalls the input: a first pass, then doubling rounds, then the Kasai
// LCP pass; each step is a read, modify, write sequence on memories with one read and one write port each.
// Reset (synchronous, active low) clears length, flags and control; memories are not cleared.
module suffix_array_lcp_builder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  salb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output salb_pkg::t_out_item o_out_data
);

    localparam int AW = salb_pkg::AW;
    localparam int CW = salb_pkg::CODE_W;
    localparam int LW = salb_pkg::LCP_W;
    localparam int ML = salb_pkg::MAX_LEN;

    typedef enum logic [28:0] {
        S_IDLE  = 29'd1 << 0,  S_CLR   = 29'd1 << 1,  S_F_RD  = 29'd1 << 2,
        S_F_WR  = 29'd1 << 3,  S_F_CNT = 29'd1 << 4,  S_PX_RD = 29'd1 << 5,
        S_PX_WR = 29'd1 << 6,  S_SC_RD = 29'd1 << 7,  S_SC_CT = 29'd1 << 8,
        S_SC_WR = 29'd1 << 9,  S_Y1    = 29'd1 << 10, S_Y2_RD = 29'd1 << 11,
        S_Y2_WR = 29'd1 << 12, S_FK_RD = 29'd1 << 13, S_FK_RK = 29'd1 << 14,
        S_FK_WR = 29'd1 << 15, S_FK_CT = 29'd1 << 16, S_CP_RD = 29'd1 << 17,
        S_CP_WR = 29'd1 << 18, S_RR_RD = 29'd1 << 19, S_RR_O1 = 29'd1 << 20,
        S_RR_O2 = 29'd1 << 21, S_RR_WR = 29'd1 << 22, S_L_RD  = 29'd1 << 23,
        S_L_R   = 29'd1 << 24, S_L_K   = 29'd1 << 25, S_L_T1  = 29'd1 << 26,
        S_L_T2  = 29'd1 << 27, S_L_T3  = 29'd1 << 28
    } t_state;

    // memories, 1-based entries
    logic [CW-1:0] mem_text  [0:ML];
    logic [AW-1:0] mem_sa    [0:ML];
    logic [AW-1:0] mem_rk    [0:ML];
    logic [AW-1:0] mem_old   [0:ML];
    logic [AW-1:0] mem_cnt   [0:ML];
    logic [AW-1:0] mem_y     [0:ML];
    logic [AW-1:0] mem_fk    [0:ML];
    logic [LW-1:0] mem_lcp   [0:ML];

    logic [CW-1:0] r_text_q;
    logic [AW-1:0] r_sa_q, r_rk_q, r_old_q, r_cnt_q, r_y_q, r_fk_q;
    logic [LW-1:0] r_lcp_q;

    logic          text_we, text_re, sa_we, sa_re, rk_we, rk_re, old_we, old_re;
    logic          cnt_we, cnt_re, y_we, y_re, fk_we, fk_re, lcp_we, lcp_re;
    logic [AW-1:0] text_wa, text_ra, sa_wa, sa_ra, rk_wa, rk_ra, old_wa, old_ra;
    logic [AW-1:0] cnt_wa, cnt_ra, y_wa, y_ra, fk_wa, fk_ra, lcp_wa, lcp_ra;
    logic [CW-1:0] text_wd;
    logic [AW-1:0] sa_wd, rk_wd, old_wd, cnt_wd, y_wd, fk_wd;
    logic [LW-1:0] lcp_wd;

    t_state        r_state, n_state;
    logic [AW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf, r_built, n_built, r_first, n_first;
    logic [AW-1:0] r_i, n_i, r_p, n_p, r_m, n_m, r_acc, n_acc, r_key, n_key;
    logic [AW-1:0] r_yv, n_yv, r_b, n_b, r_v1, n_v1, r_pv1, n_pv1, r_pv2, n_pv2;
    logic [AW-1:0] r_r, n_r, r_k, n_k, r_j, n_j;
    logic [AW:0]   r_w, n_w;
    logic          r_bw_ok, n_bw_ok;
    logic [CW-1:0] r_t1, n_t1;
    logic          r_pend, n_pend, r_oor, n_oor, r_qovf, n_qovf;
    logic          r_out_valid, n_out_valid;
    salb_pkg::t_out_item r_out, n_out;

    logic          in_acc;
    logic [AW-1:0] len_base, v2, np;
    logic [AW:0]   iw, bw, ij, kj;
    logic          diff;

    assign o_in_stall  = (r_state != S_IDLE) || r_pend;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state; n_len = r_len; n_ovf = r_ovf; n_built = r_built;
        n_first = r_first; n_i = r_i; n_p = r_p; n_m = r_m; n_acc = r_acc;
        n_key = r_key; n_yv = r_yv; n_b = r_b; n_v1 = r_v1; n_pv1 = r_pv1;
        n_pv2 = r_pv2; n_r = r_r; n_k = r_k; n_j = r_j; n_w = r_w;
        n_bw_ok = r_bw_ok; n_t1 = r_t1; n_pend = r_pend; n_oor = r_oor;
        n_qovf = r_qovf; n_out_valid = r_out_valid; n_out = r_out;
        text_we = 1'b0; text_re = 1'b0; sa_we = 1'b0; sa_re = 1'b0;
        rk_we = 1'b0; rk_re = 1'b0; old_we = 1'b0; old_re = 1'b0;
        cnt_we = 1'b0; cnt_re = 1'b0; y_we = 1'b0; y_re = 1'b0;
        fk_we = 1'b0; fk_re = 1'b0; lcp_we = 1'b0; lcp_re = 1'b0;
        text_wa = '0; text_ra = '0; sa_wa = '0; sa_ra = '0; rk_wa = '0; rk_ra = '0;
        old_wa = '0; old_ra = '0; cnt_wa = '0; cnt_ra = '0; y_wa = '0; y_ra = '0;
        fk_wa = '0; fk_ra = '0; lcp_wa = '0; lcp_ra = '0;
        text_wd = '0; sa_wd = '0; rk_wd = '0; old_wd = '0; cnt_wd = '0;
        y_wd = '0; fk_wd = '0; lcp_wd = '0;
        len_base = r_built ? '0 : r_len;
        iw   = {1'b0, r_i} + r_w;
        bw   = {1'b0, r_sa_q} + r_w;
        ij   = {1'b0, r_i} + {1'b0, r_j};
        kj   = {1'b0, r_k} + {1'b0, r_j};
        v2   = r_bw_ok ? r_old_q : '0;
        diff = (r_i == AW'(1)) || (r_v1 != r_pv1) || (v2 != r_pv2);
        np   = r_p + AW'(diff);

        // output register: load a pending read, drop a taken transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_pend && (!r_out_valid || !i_out_stall)) begin
            n_pend      = 1'b0;
            n_out_valid = 1'b1;
            n_out.out_of_range     = r_oor;
            n_out.overflowed       = r_qovf;
            n_out.suffix_start     = r_oor ? '0 : r_sa_q;
            n_out.lcp              = r_oor ? '0 : r_lcp_q;
            n_out.rank_of_position = r_oor ? '0 : r_rk_q;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.mode == salb_pkg::MODE_READ) begin
                    sa_re = 1'b1; rk_re = 1'b1; lcp_re = 1'b1;
                    sa_ra = i_in_data.index; rk_ra = i_in_data.index;
                    lcp_ra = i_in_data.index;
                    n_pend = 1'b1;
                    n_qovf = r_ovf;
                    n_oor  = !r_built || (i_in_data.index == '0) ||
                             (i_in_data.index > r_len);
                end else if (in_acc) begin
                    n_built = 1'b0;
                    n_ovf   = r_built ? 1'b0 : r_ovf;
                    n_len   = len_base;
                    if (len_base < AW'(ML)) begin
                        n_len   = len_base + AW'(1);
                        text_we = 1'b1;
                        text_wa = len_base + AW'(1);
                        text_wd = i_in_data.char_code;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_char) begin
                        n_state = S_CLR;
                        n_first = 1'b1;
                        n_m     = AW'(salb_pkg::ALPHA_KEYS);
                        n_i     = '0;
                    end
                end
            end
            S_CLR: begin
                cnt_we = 1'b1; cnt_wa = r_i; cnt_wd = '0;
                if (r_i == r_m) begin
                    n_i     = AW'(1);
                    n_state = r_first ? S_F_RD : S_FK_RD;
                end else begin
                    n_i = r_i + AW'(1);
                end
            end
            S_F_RD: begin
                text_re = 1'b1; text_ra = r_i; n_state = S_F_WR;
            end
            S_F_WR: begin
                n_key = AW'(r_text_q) + AW'(1);
                rk_we = 1'b1; rk_wa = r_i; rk_wd = AW'(r_text_q) + AW'(1);
                y_we  = 1'b1; y_wa = r_i; y_wd = r_i;
                fk_we = 1'b1; fk_wa = r_i; fk_wd = AW'(r_text_q) + AW'(1);
                cnt_re = 1'b1; cnt_ra = AW'(r_text_q) + AW'(1);
                n_state = S_F_CNT;
            end
            S_F_CNT, S_FK_CT: begin
                cnt_we = 1'b1; cnt_wa = r_key; cnt_wd = r_cnt_q + AW'(1);
                if (r_i == r_len) begin
                    n_i = AW'(1); n_acc = '0; n_state = S_PX_RD;
                end else begin
                    n_i = r_i + AW'(1);
                    n_state = (r_state == S_F_CNT) ? S_F_RD : S_FK_RD;
                end
            end
            S_PX_RD: begin
                cnt_re = 1'b1; cnt_ra = r_i; n_state = S_PX_WR;
            end
            S_PX_WR: begin
                n_acc  = r_acc + r_cnt_q;
                cnt_we = 1'b1; cnt_wa = r_i; cnt_wd = r_acc + r_cnt_q;
                if (r_i == r_m) begin
                    n_i = r_len; n_state = S_SC_RD;
                end else begin
                    n_i = r_i + AW'(1); n_state = S_PX_RD;
                end
            end
            S_SC_RD: begin
                fk_re = 1'b1; fk_ra = r_i; y_re = 1'b1; y_ra = r_i;
                n_state = S_SC_CT;
            end
            S_SC_CT: begin
                n_key = r_fk_q; n_yv = r_y_q;
                cnt_re = 1'b1; cnt_ra = r_fk_q;
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                sa_we  = 1'b1; sa_wa = r_cnt_q; sa_wd = r_yv;
                cnt_we = 1'b1; cnt_wa = r_key; cnt_wd = r_cnt_q - AW'(1);
                if (r_i == AW'(1)) begin
                    if (r_first) begin
                        n_first = 1'b0;
                        n_w     = (AW+1)'(1);
                        n_i     = r_len;
                        n_p     = '0;
                        n_state = S_Y1;
                    end else begin
                        n_i = AW'(1); n_state = S_CP_RD;
                    end
                end else begin
                    n_i = r_i - AW'(1); n_state = S_SC_RD;
                end
            end
            S_Y1: begin
                // suffixes whose second half runs past the end come first
                if (r_i != '0 && iw > {1'b0, r_len}) begin
                    y_we = 1'b1; y_wa = r_p + AW'(1); y_wd = r_i;
                    n_p  = r_p + AW'(1);
                    n_i  = r_i - AW'(1);
                end else begin
                    n_i = AW'(1); n_state = S_Y2_RD;
                end
            end
            S_Y2_RD: begin
                sa_re = 1'b1; sa_ra = r_i; n_state = S_Y2_WR;
            end
            S_Y2_WR: begin
                if ({1'b0, r_sa_q} > r_w) begin
                    y_we = 1'b1; y_wa = r_p + AW'(1);
                    y_wd = AW'({1'b0, r_sa_q} - r_w);
                    n_p  = r_p + AW'(1);
                end
                if (r_i == r_len) begin
                    n_i = '0; n_state = S_CLR;
                end else begin
                    n_i = r_i + AW'(1); n_state = S_Y2_RD;
                end
            end
            S_FK_RD: begin
                y_re = 1'b1; y_ra = r_i; n_state = S_FK_RK;
            end
            S_FK_RK: begin
                rk_re = 1'b1; rk_ra = r_y_q; n_state = S_FK_WR;
            end
            S_FK_WR: begin
                n_key = r_rk_q;
                fk_we = 1'b1; fk_wa = r_i; fk_wd = r_rk_q;
                cnt_re = 1'b1; cnt_ra = r_rk_q;
                n_state = S_FK_CT;
            end
            S_CP_RD: begin
                rk_re = 1'b1; rk_ra = r_i; n_state = S_CP_WR;
            end
            S_CP_WR: begin
                old_we = 1'b1; old_wa = r_i; old_wd = r_rk_q;
                if (r_i == r_len) begin
                    n_i = AW'(1); n_p = '0; n_state = S_RR_RD;
                end else begin
                    n_i = r_i + AW'(1); n_state = S_CP_RD;
                end
            end
            S_RR_RD: begin
                sa_re = 1'b1; sa_ra = r_i; n_state = S_RR_O1;
            end
            S_RR_O1: begin
                n_b     = r_sa_q;
                n_bw_ok = bw <= {1'b0, r_len};
                old_re  = 1'b1; old_ra = r_sa_q;
                n_state = S_RR_O2;
            end
            S_RR_O2: begin
                n_v1   = r_old_q;
                old_re = r_bw_ok; old_ra = AW'({1'b0, r_b} + r_w);
                n_state = S_RR_WR;
            end
            S_RR_WR: begin
                rk_we = 1'b1; rk_wa = r_b; rk_wd = np;
                n_p = np; n_pv1 = r_v1; n_pv2 = v2;
                if (r_i == r_len) begin
                    if (np == r_len) begin
                        n_i = AW'(1); n_j = '0; n_state = S_L_RD;
                    end else begin
                        n_m = np; n_w = r_w << 1; n_i = r_len; n_p = '0;
                        n_state = S_Y1;
                    end
                end else begin
                    n_i = r_i + AW'(1); n_state = S_RR_RD;
                end
            end
            S_L_RD: begin
                rk_re = 1'b1; rk_ra = r_i; n_state = S_L_R;
            end
            S_L_R: begin
                n_r = r_rk_q;
                if (r_rk_q <= AW'(1)) begin
                    lcp_we = 1'b1; lcp_wa = AW'(1); lcp_wd = '0;
                    n_j = '0;
                    if (r_i == r_len) begin
                        n_built = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_i = r_i + AW'(1); n_state = S_L_RD;
                    end
                end else begin
                    n_j   = (r_j != '0) ? r_j - AW'(1) : r_j;
                    sa_re = 1'b1; sa_ra = r_rk_q - AW'(1);
                    n_state = S_L_K;
                end
            end
            S_L_K: begin
                n_k = r_sa_q; n_state = S_L_T1;
            end
            S_L_T1: begin
                if (ij <= {1'b0, r_len} && kj <= {1'b0, r_len}) begin
                    text_re = 1'b1; text_ra = ij[AW-1:0];
                    n_state = S_L_T2;
                end else begin
                    lcp_we = 1'b1; lcp_wa = r_r; lcp_wd = r_j[LW-1:0];
                    if (r_i == r_len) begin
                        n_built = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_i = r_i + AW'(1); n_state = S_L_RD;
                    end
                end
            end
            S_L_T2: begin
                n_t1 = r_text_q;
                text_re = 1'b1; text_ra = kj[AW-1:0];
                n_state = S_L_T3;
            end
            S_L_T3: begin
                if (r_text_q == r_t1) begin
                    n_j = r_j + AW'(1); n_state = S_L_T1;
                end else begin
                    lcp_we = 1'b1; lcp_wa = r_r; lcp_wd = r_j[LW-1:0];
                    if (r_i == r_len) begin
                        n_built = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_i = r_i + AW'(1); n_state = S_L_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (text_we) mem_text[text_wa] <= text_wd;
        if (text_re) r_text_q <= mem_text[text_ra];
        if (sa_we)   mem_sa[sa_wa] <= sa_wd;
        if (sa_re)   r_sa_q <= mem_sa[sa_ra];
        if (rk_we)   mem_rk[rk_wa] <= rk_wd;
        if (rk_re)   r_rk_q <= mem_rk[rk_ra];
        if (old_we)  mem_old[old_wa] <= old_wd;
        if (old_re)  r_old_q <= mem_old[old_ra];
        if (cnt_we)  mem_cnt[cnt_wa] <= cnt_wd;
        if (cnt_re)  r_cnt_q <= mem_cnt[cnt_ra];
        if (y_we)    mem_y[y_wa] <= y_wd;
        if (y_re)    r_y_q <= mem_y[y_ra];
        if (fk_we)   mem_fk[fk_wa] <= fk_wd;
        if (fk_re)   r_fk_q <= mem_fk[fk_ra];
        if (lcp_we)  mem_lcp[lcp_wa] <= lcp_wd;
        if (lcp_re)  r_lcp_q <= mem_lcp[lcp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_built     <= 1'b0;
            r_first     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_built     <= n_built;
            r_first     <= n_first;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_p <= n_p; r_m <= n_m; r_acc <= n_acc; r_key <= n_key;
        r_yv <= n_yv; r_b <= n_b; r_v1 <= n_v1; r_pv1 <= n_pv1; r_pv2 <= n_pv2;
        r_r <= n_r; r_k <= n_k; r_j <= n_j; r_w <= n_w; r_bw_ok <= n_bw_ok;
        r_t1 <= n_t1; r_oor <= n_oor; r_qovf <= n_qovf; r_out <= n_out;
    end

endmodule

FILE: sv/salb_checker.sv
// Port-level checker for the suffix array builder, bound to the top level
`include "suffix_array_lcp_builder_macros.svh"

module salb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input salb_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input salb_pkg::t_out_item o_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    `SALB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `SALB_ASSERT_NEXT(a_build_busy, in_xfer && i_in_data.mode == salb_pkg::MODE_APPEND && i_in_data.last_char, o_in_stall, "build did not stall input")
    `SALB_ASSERT_NEXT(a_read_busy, in_xfer && i_in_data.mode == salb_pkg::MODE_READ, o_in_stall, "read did not hold input")
    `SALB_ASSERT_NOW(a_oor_zero, o_out_valid && o_out_data.out_of_range, o_out_data.suffix_start == '0 && o_out_data.lcp == '0 && o_out_data.rank_of_position == '0, "invalid read carries data")

endmodule

bind suffix_array_lcp_builder salb_checker u_salb_checker (.*);
